@@ design/mtr_pkg.sv @@
// Shared types, constants and helper functions of the Mersenne twister generator.
// No dependencies; imported by the controller, datapath and top level.
package mtr_pkg;

    localparam int unsigned TW_N          = 624;
    localparam int unsigned TW_M          = 397;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned KEY_WORDS_DEF = 16;
    localparam int unsigned RES_W         = 53;

    localparam logic [31:0] TW_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0] TW_UPPER   = 32'h8000_0000;
    localparam logic [31:0] TW_LOWER   = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam logic [31:0] KEY_MULT   = 32'd1664525;
    localparam logic [31:0] MIX_MULT   = 32'd1566083941;
    localparam logic [31:0] KEY_SEED   = 32'd19650218;

    localparam logic [IDX_W-1:0] IDX_N    = IDX_W'(TW_N);
    localparam logic [IDX_W-1:0] IDX_M    = IDX_W'(TW_M);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TW_N - 1);

    typedef enum logic [2:0] {
        MODE_WORD  = 3'd0,
        MODE_SEED  = 3'd1,
        MODE_KEY   = 3'd2,
        MODE_FRAC  = 3'd3,
        MODE_RANGE = 3'd4
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_S1_INIT, ST_S1_MUL, ST_S1_WR,
        ST_K_INIT, ST_K1_RD, ST_K1_WR, ST_K1_WRAP,
        ST_K2_INIT, ST_K2_RD, ST_K2_WR, ST_K2_WRAP, ST_K_TOP,
        ST_DRAW_CHK, ST_T_RD0, ST_T_CUR, ST_T_NX, ST_T_RDM, ST_T_WR,
        ST_D_RD, ST_D_TMP, ST_M_B, ST_M_A, ST_DONE
    } state_t;

    typedef enum logic [1:0] {ADDR_I, ADDR_I1, ADDR_IM, ADDR_WIDX} rd_addr_t;
    typedef enum logic [2:0] {
        WD_INIT, WD_SEED, WD_KEY, WD_MIX, WD_TWIST, WD_P, WD_TOP
    } wr_data_t;
    typedef enum logic [2:0] {MUL_SEED, MUL_KEY, MUL_MIX, MUL_A, MUL_B} mul_sel_t;
    typedef enum logic [1:0] {I_HOLD, I_ZERO, I_ONE, I_INC} i_op_t;
    typedef enum logic [1:0] {K_HOLD, K_LOAD1, K_LOAD2, K_DEC} k_op_t;
    typedef enum logic [1:0] {J_HOLD, J_ZERO, J_STEP} j_op_t;
    typedef enum logic [2:0] {RES_ZERO, RES_WORD, RES_FRAC, RES_RANGE, RES_LOW} res_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     key_push;
        logic     key_clear;
        logic     key_rd;
        logic     mem_rd;
        rd_addr_t rd_addr;
        logic     mem_wr;
        wr_data_t wr_data;
        logic     wr_zero;
        logic     p_load;
        logic     seed_const;
        mul_sel_t mul_sel;
        logic     prod_load;
        logic     acc_load;
        i_op_t    i_op;
        k_op_t    k_op;
        j_op_t    j_op;
        logic     widx_full_set;
        logic     widx_zero;
        logic     widx_inc;
        logic     cur_load;
        logic     nxt_load;
        logic     cur_shift;
        logic     tmp_first;
        logic     tmp_second;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic widx_full;
        logic i_last;
        logic k_last;
        logic k_zero;
        logic low_ge_high;
    } status_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ design/mtr_ctrl.sv @@
// Sequencer of the Mersenne twister generator: handshakes and command issue.
// Depends on mtr_pkg.
module mtr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       mode,
    input  logic             key_last,
    output logic             out_valid,
    input  logic             out_ready,
    input  mtr_pkg::status_t status,
    output mtr_pkg::cmd_t    cmd
);
    import mtr_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   last_reg, last_next;
    logic   second_reg, second_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_WORD;
            last_reg      <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            last_reg      <= last_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        last_next      = last_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = mode_t'(mode);
                    last_next   = key_last;
                    second_next = 1'b0;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (mode_reg)
                    MODE_WORD, MODE_FRAC: state_next = ST_DRAW_CHK;
                    MODE_RANGE: state_next = status.low_ge_high ? ST_DONE : ST_DRAW_CHK;
                    MODE_SEED:  state_next = ST_S1_INIT;
                    MODE_KEY:   state_next = last_reg ? ST_S1_INIT : ST_DONE;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_S1_INIT: state_next = ST_S1_MUL;
            ST_S1_MUL:  state_next = ST_S1_WR;
            ST_S1_WR:
            begin
                if (!status.i_last)
                    state_next = ST_S1_MUL;
                else if (mode_reg == MODE_SEED)
                    state_next = ST_DONE;
                else
                    state_next = ST_K_INIT;
            end
            ST_K_INIT: state_next = ST_K1_RD;
            ST_K1_RD:  state_next = ST_K1_WR;
            ST_K1_WR:
            begin
                if (status.i_last)
                    state_next = ST_K1_WRAP;
                else
                    state_next = status.k_last ? ST_K2_INIT : ST_K1_RD;
            end
            ST_K1_WRAP: state_next = status.k_zero ? ST_K2_INIT : ST_K1_RD;
            ST_K2_INIT: state_next = ST_K2_RD;
            ST_K2_RD:   state_next = ST_K2_WR;
            ST_K2_WR:
            begin
                if (status.i_last)
                    state_next = ST_K2_WRAP;
                else
                    state_next = status.k_last ? ST_K_TOP : ST_K2_RD;
            end
            ST_K2_WRAP: state_next = status.k_zero ? ST_K_TOP : ST_K2_RD;
            ST_K_TOP:   state_next = ST_DONE;
            ST_DRAW_CHK: state_next = status.widx_full ? ST_T_RD0 : ST_D_RD;
            ST_T_RD0:  state_next = ST_T_CUR;
            ST_T_CUR:  state_next = ST_T_NX;
            ST_T_NX:   state_next = ST_T_RDM;
            ST_T_RDM:  state_next = ST_T_WR;
            ST_T_WR:   state_next = status.i_last ? ST_D_RD : ST_T_NX;
            ST_D_RD:   state_next = ST_D_TMP;
            ST_D_TMP:
            begin
                if (mode_reg == MODE_WORD)
                    state_next = ST_DONE;
                else if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = ST_DRAW_CHK;
                end
                else
                    state_next = (mode_reg == MODE_RANGE) ? ST_M_B : ST_DONE;
            end
            ST_M_B: state_next = ST_M_A;
            ST_M_A: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd         = '0;
        cmd.in_load = accept;
        case (state_reg)
            ST_DISPATCH:
                cmd.key_push = (mode_reg == MODE_KEY);
            ST_S1_INIT:
            begin
                cmd.mem_wr        = 1'b1;
                cmd.wr_data       = WD_INIT;
                cmd.wr_zero       = 1'b1;
                cmd.p_load        = 1'b1;
                cmd.seed_const    = (mode_reg != MODE_SEED);
                cmd.i_op          = I_ONE;
                cmd.widx_full_set = 1'b1;
            end
            ST_S1_MUL:
            begin
                cmd.mul_sel   = MUL_SEED;
                cmd.prod_load = 1'b1;
            end
            ST_S1_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_data = WD_SEED;
                cmd.p_load  = 1'b1;
                cmd.i_op    = status.i_last ? I_HOLD : I_INC;
            end
            ST_K_INIT:
            begin
                // mixing starts from word 0, which still holds the key seed
                cmd.wr_data    = WD_INIT;
                cmd.seed_const = 1'b1;
                cmd.p_load     = 1'b1;
                cmd.i_op       = I_ONE;
                cmd.j_op       = J_ZERO;
                cmd.k_op       = K_LOAD1;
            end
            ST_K1_RD:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.rd_addr   = ADDR_I;
                cmd.key_rd    = 1'b1;
                cmd.mul_sel   = MUL_KEY;
                cmd.prod_load = 1'b1;
            end
            ST_K1_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_data = WD_KEY;
                cmd.p_load  = 1'b1;
                cmd.k_op    = K_DEC;
                cmd.j_op    = J_STEP;
                cmd.i_op    = status.i_last ? I_HOLD : I_INC;
            end
            ST_K1_WRAP, ST_K2_WRAP:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_data = WD_P;
                cmd.wr_zero = 1'b1;
                cmd.i_op    = I_ONE;
            end
            ST_K2_INIT:
                cmd.k_op = K_LOAD2;
            ST_K2_RD:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.rd_addr   = ADDR_I;
                cmd.mul_sel   = MUL_MIX;
                cmd.prod_load = 1'b1;
            end
            ST_K2_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_data = WD_MIX;
                cmd.p_load  = 1'b1;
                cmd.k_op    = K_DEC;
                cmd.i_op    = status.i_last ? I_HOLD : I_INC;
            end
            ST_K_TOP:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.wr_data   = WD_TOP;
                cmd.wr_zero   = 1'b1;
                cmd.key_clear = 1'b1;
            end
            ST_DRAW_CHK:
                cmd.i_op = I_ZERO;
            ST_T_RD0:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = ADDR_I;
            end
            ST_T_CUR:
                cmd.cur_load = 1'b1;
            ST_T_NX:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = ADDR_I1;
            end
            ST_T_RDM:
            begin
                cmd.nxt_load = 1'b1;
                cmd.mem_rd   = 1'b1;
                cmd.rd_addr  = ADDR_IM;
            end
            ST_T_WR:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.wr_data   = WD_TWIST;
                cmd.cur_shift = 1'b1;
                cmd.widx_zero = status.i_last;
                cmd.i_op      = status.i_last ? I_HOLD : I_INC;
            end
            ST_D_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = ADDR_WIDX;
            end
            ST_D_TMP:
            begin
                cmd.widx_inc   = 1'b1;
                cmd.tmp_first  = !second_reg;
                cmd.tmp_second = second_reg;
            end
            ST_M_B:
            begin
                cmd.mul_sel   = MUL_B;
                cmd.prod_load = 1'b1;
            end
            ST_M_A:
            begin
                cmd.mul_sel  = MUL_A;
                cmd.acc_load = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = out_free;
                case (mode_reg)
                    MODE_WORD:  cmd.res_sel = RES_WORD;
                    MODE_FRAC:  cmd.res_sel = RES_FRAC;
                    MODE_RANGE: cmd.res_sel = status.low_ge_high ? RES_LOW : RES_RANGE;
                    default:    cmd.res_sel = RES_ZERO;
                endcase
            end
            default: ;
        endcase
    end

endmodule

@@ design/mtr_datapath.sv @@
// Datapath of the Mersenne twister generator: state memory, key store,
// shared multiplier, counters and result register. Depends on mtr_pkg.
module mtr_datapath #(
    parameter int unsigned KEY_WORDS = mtr_pkg::KEY_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtr_pkg::cmd_t            cmd,
    output mtr_pkg::status_t         status,
    input  logic [2:0]               mode,
    input  logic [31:0]              value,
    input  logic [31:0]              range_low,
    input  logic [31:0]              range_high,
    output logic [mtr_pkg::RES_W-1:0] result,
    output logic                     key_overflow
);
    import mtr_pkg::*;

    localparam int unsigned KCW = $clog2(KEY_WORDS + 1);
    localparam int unsigned KIW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

    logic [31:0] mem [0:TW_N-1];
    logic [31:0] key_mem [0:KEY_WORDS-1];

    logic [31:0]      value_reg, low_reg, high_reg;
    logic             is_key_reg;
    logic [31:0]      rd_reg, key_rd_reg;
    logic [31:0]      p_reg, cur_reg, nxt_reg;
    logic [63:0]      prod_reg;
    logic [59:0]      acc_reg;
    logic [31:0]      w_reg;
    logic [26:0]      a_reg;
    logic [25:0]      b_reg;
    logic [IDX_W-1:0] i_reg, k_reg, widx_reg;
    logic [KIW-1:0]   j_reg;
    logic [KCW-1:0]   count_reg;
    logic             ovf_reg;
    logic [RES_W-1:0] res_reg;
    logic             res_ovf_reg;

    logic [IDX_W-1:0] i_plus1, i_plusm_raw, i_plusm, rd_addr, wr_addr;
    logic [31:0]      span, mul_a, mul_b, wdata, y, seed_val, draw;
    logic [63:0]      prod;
    logic [KCW-1:0]   key_len, j_inc;
    logic [31:0]      off;

    assign span        = high_reg - low_reg + 32'd1;
    assign i_plus1     = (i_reg == IDX_LAST) ? '0 : i_reg + 1'b1;
    assign i_plusm_raw = i_reg + IDX_M;
    assign i_plusm     = (i_plusm_raw >= IDX_N) ? i_plusm_raw - IDX_N : i_plusm_raw;
    assign y           = (cur_reg & TW_UPPER) | (nxt_reg & TW_LOWER);
    assign seed_val    = cmd.seed_const ? KEY_SEED : value_reg;
    assign draw        = temper(rd_reg);
    assign key_len     = (count_reg == '0) ? KCW'(1) : count_reg;
    assign j_inc       = KCW'(j_reg) + 1'b1;
    assign off         = acc_reg[58:27];

    always_comb
    begin
        case (cmd.rd_addr)
            ADDR_I:    rd_addr = i_reg;
            ADDR_I1:   rd_addr = i_plus1;
            ADDR_IM:   rd_addr = i_plusm;
            ADDR_WIDX: rd_addr = widx_reg;
            default:   rd_addr = i_reg;
        endcase
    end

    assign wr_addr = cmd.wr_zero ? '0 : i_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEED: begin mul_a = p_reg ^ (p_reg >> 30); mul_b = SEED_MULT; end
            MUL_KEY:  begin mul_a = p_reg ^ (p_reg >> 30); mul_b = KEY_MULT;  end
            MUL_MIX:  begin mul_a = p_reg ^ (p_reg >> 30); mul_b = MIX_MULT;  end
            MUL_A:    begin mul_a = {5'b0, a_reg};          mul_b = span;      end
            MUL_B:    begin mul_a = {6'b0, b_reg};          mul_b = span;      end
            default:  begin mul_a = '0;                     mul_b = '0;        end
        endcase
    end

    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    always_comb
    begin
        case (cmd.wr_data)
            WD_INIT:  wdata = seed_val;
            WD_SEED:  wdata = prod_reg[31:0] + 32'(i_reg);
            WD_KEY:   wdata = (rd_reg ^ prod_reg[31:0]) + key_rd_reg + 32'(j_reg);
            WD_MIX:   wdata = (rd_reg ^ prod_reg[31:0]) - 32'(i_reg);
            WD_TWIST: wdata = rd_reg ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'h0);
            WD_P:     wdata = p_reg;
            WD_TOP:   wdata = TW_UPPER;
            default:  wdata = p_reg;
        endcase
    end

    // state memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= wdata;
        if (cmd.mem_rd)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_push && (count_reg < KCW'(KEY_WORDS)))
            key_mem[count_reg[KIW-1:0]] <= value_reg;
        if (cmd.key_rd)
            key_rd_reg <= key_mem[j_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            value_reg  <= value;
            low_reg    <= range_low;
            high_reg   <= range_high;
            is_key_reg <= (mode == MODE_KEY);
        end
        if (cmd.p_load)    p_reg    <= wdata;
        if (cmd.prod_load) prod_reg <= prod;
        if (cmd.acc_load)  acc_reg  <= prod[59:0] + {22'b0, prod_reg[63:26]};
        if (cmd.cur_load)  cur_reg  <= rd_reg;
        if (cmd.cur_shift) cur_reg  <= nxt_reg;
        if (cmd.nxt_load)  nxt_reg  <= rd_reg;
        if (cmd.tmp_first)
        begin
            w_reg <= draw;
            a_reg <= draw[31:5];
        end
        if (cmd.tmp_second) b_reg <= draw[31:6];
        if (cmd.out_load)
        begin
            res_ovf_reg <= ovf_reg;
            case (cmd.res_sel)
                RES_WORD:  res_reg <= RES_W'(w_reg);
                RES_FRAC:  res_reg <= {a_reg, b_reg};
                RES_RANGE: res_reg <= RES_W'(low_reg + off);
                RES_LOW:   res_reg <= RES_W'(low_reg);
                default:   res_reg <= '0;
            endcase
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            widx_reg  <= IDX_N;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.i_op)
                I_ZERO:  i_reg <= '0;
                I_ONE:   i_reg <= IDX_W'(1);
                I_INC:   i_reg <= i_reg + 1'b1;
                default: i_reg <= i_reg;
            endcase
            case (cmd.k_op)
                K_LOAD1: k_reg <= IDX_N;
                K_LOAD2: k_reg <= IDX_LAST;
                K_DEC:   k_reg <= k_reg - 1'b1;
                default: k_reg <= k_reg;
            endcase
            case (cmd.j_op)
                J_ZERO:  j_reg <= '0;
                J_STEP:  j_reg <= (j_inc >= key_len) ? '0 : j_inc[KIW-1:0];
                default: j_reg <= j_reg;
            endcase
            if (cmd.widx_full_set)
                widx_reg <= IDX_N;
            else if (cmd.widx_zero)
                widx_reg <= '0;
            else if (cmd.widx_inc)
                widx_reg <= widx_reg + 1'b1;
            if (cmd.in_load)
                ovf_reg <= 1'b0;
            else if (cmd.key_push && is_key_reg)
            begin
                if (count_reg < KCW'(KEY_WORDS))
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.key_clear)
                count_reg <= '0;
        end
    end

    assign status.widx_full   = (widx_reg == IDX_N);
    assign status.i_last      = (i_reg == IDX_LAST);
    assign status.k_last      = (k_reg == IDX_W'(1));
    assign status.k_zero      = (k_reg == '0);
    assign status.low_ge_high = (low_reg >= high_reg);

    assign result       = res_reg;
    assign key_overflow = res_ovf_reg;

endmodule

@@ design/mersenne_twister_rng.sv @@
// Top level of the 32-bit Mersenne twister generator (624-word state).
// Depends on mtr_pkg, mtr_ctrl and mtr_datapath.
//
// Usage: present a command item on the input channel (in_valid/in_ready)
// with mode, value, key_last, range_low and range_high. Every item gives
// exactly one result item on the output channel (out_valid/out_ready):
// result and key_overflow.
//   mode 0: one tempered word. mode 1: seed from value.
//   mode 2: store a key word; key_last starts array seeding over the store.
//   mode 3: 53-bit fraction numerator. mode 4: inclusive range draw.
// Flow: one item is in work at a time. A draw that finds the state used up
// first regenerates all 624 words, one word at a time, through the single
// read port of the state memory. Fraction and range draws take two draws,
// and a range draw then multiplies both by the span. Seeding from a value
// goes word by word: multiply, then write. Key seeding then adds two
// mixing passes.
// Reset clears the sequencer and key count and marks the state used up; the
// state memory holds nothing defined until seeded, so seed before drawing.
// A stalled receiver holds the finished result in the output register; the
// next item is accepted, but its result waits until the register is taken.
module mersenne_twister_rng #(
    parameter int unsigned KEY_WORDS = mtr_pkg::KEY_WORDS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                mode,
    input  logic [31:0]               value,
    input  logic                      key_last,
    input  logic [31:0]               range_low,
    input  logic [31:0]               range_high,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mtr_pkg::RES_W-1:0] result,
    output logic                      key_overflow
);
    import mtr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: handshakes and command issue
    mtr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key_last  (key_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // state memory, key store, multiplier and result register
    mtr_datapath #(
        .KEY_WORDS (KEY_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .value        (value),
        .range_low    (range_low),
        .range_high   (range_high),
        .result       (result),
        .key_overflow (key_overflow)
    );

    // one item at a time: an accepted item drops ready on the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in work");

    // never read the word at the index once the state is used up
    a_no_stale_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_rd && (cmd.rd_addr == ADDR_WIDX)) |-> !status.widx_full)
        else $error("draw read past the end of the state");

    // the result register only loads when its previous item is gone
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten before it was taken");

endmodule
